// File: design/tcr_pkg.sv
// Shared types, constants and helper functions for the triangle coverage rasterizer.
package tcr_pkg;

	localparam int COORD_BITS = 12;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = 2 * DIFF_BITS;
	localparam int SUM_BITS   = PROD_BITS + 2;
	localparam int QDEPTH     = 4;
	localparam int QADDR_BITS = $clog2(QDEPTH);
	localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_STEP = 1'b1;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0] diff_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;
	typedef logic signed [SUM_BITS-1:0] sum_t;

	typedef struct packed {
		coord_t ax;
		coord_t ay;
		diff_t  e1x;
		diff_t  e1y;
		diff_t  e2x;
		diff_t  e2y;
	} tri_t;

	typedef struct packed {
		logic   pix;
		coord_t x;
		coord_t y;
		logic   last;
	} meta_t;

	typedef struct packed {
		meta_t meta;
		tri_t  geom;
	} entry_t;

	function automatic coord_t min3(input coord_t a, input coord_t b, input coord_t c);
		coord_t m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic coord_t max3(input coord_t a, input coord_t b, input coord_t c);
		coord_t m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	function automatic diff_t coord_diff(input coord_t a, input coord_t b);
		return $signed({1'b0, a}) - $signed({1'b0, b});
	endfunction

endpackage

// File: design/tcr_front.sv
// Front end: takes load and step transactions, keeps the triangle and scan cursor.
module tcr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 kind,
	input  tcr_pkg::coord_t      vertex_ax,
	input  tcr_pkg::coord_t      vertex_ay,
	input  tcr_pkg::coord_t      vertex_bx,
	input  tcr_pkg::coord_t      vertex_by,
	input  tcr_pkg::coord_t      vertex_cx,
	input  tcr_pkg::coord_t      vertex_cy,
	output logic                 push_valid,
	input  logic                 push_stall,
	output tcr_pkg::entry_t      push_entry
);

	tcr_pkg::tri_t   tri_q;
	tcr_pkg::coord_t xmin_q, ymin_q, xmax_q, ymax_q;
	tcr_pkg::coord_t cur_x_q, cur_y_q;
	logic            active_q;
	logic            accept;
	logic            end_col, end_all;

	assign in_stall   = push_stall;
	assign push_valid = in_valid;
	assign accept     = in_valid && !push_stall;
	assign end_col    = (cur_y_q >= ymax_q);
	assign end_all    = end_col && (cur_x_q >= xmax_q);

	always_comb begin
		push_entry      = '0;
		push_entry.geom = tri_q;
		if (kind == tcr_pkg::KIND_STEP && active_q) begin
			push_entry.meta.pix  = 1'b1;
			push_entry.meta.x    = cur_x_q;
			push_entry.meta.y    = cur_y_q;
			push_entry.meta.last = end_all;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tri_q    <= '0;
			xmin_q   <= '0;
			ymin_q   <= '0;
			xmax_q   <= '0;
			ymax_q   <= '0;
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			active_q <= 1'b0;
		end else if (accept) begin
			if (kind == tcr_pkg::KIND_LOAD) begin
				tri_q.ax  <= vertex_ax;
				tri_q.ay  <= vertex_ay;
				tri_q.e1x <= tcr_pkg::coord_diff(vertex_bx, vertex_ax);
				tri_q.e1y <= tcr_pkg::coord_diff(vertex_by, vertex_ay);
				tri_q.e2x <= tcr_pkg::coord_diff(vertex_cx, vertex_ax);
				tri_q.e2y <= tcr_pkg::coord_diff(vertex_cy, vertex_ay);
				xmin_q    <= tcr_pkg::min3(vertex_ax, vertex_bx, vertex_cx);
				ymin_q    <= tcr_pkg::min3(vertex_ay, vertex_by, vertex_cy);
				xmax_q    <= tcr_pkg::max3(vertex_ax, vertex_bx, vertex_cx);
				ymax_q    <= tcr_pkg::max3(vertex_ay, vertex_by, vertex_cy);
				cur_x_q   <= tcr_pkg::min3(vertex_ax, vertex_bx, vertex_cx);
				cur_y_q   <= tcr_pkg::min3(vertex_ay, vertex_by, vertex_cy);
				active_q  <= 1'b1;
			end else if (active_q) begin
				if (end_all) begin
					active_q <= 1'b0;
				end else if (end_col) begin
					cur_y_q <= ymin_q;
					cur_x_q <= cur_x_q + 1'b1;
				end else begin
					cur_y_q <= cur_y_q + 1'b1;
				end
			end
		end
	end

endmodule

// File: design/tcr_queue.sv
// Small register queue that decouples the front end from the coverage pipeline.
module tcr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_stall,
	input  tcr_pkg::entry_t push_entry,
	output logic            pop_valid,
	input  logic            pop_stall,
	output tcr_pkg::entry_t pop_entry
);

	tcr_pkg::entry_t                     slot_q [tcr_pkg::QDEPTH];
	logic [tcr_pkg::QADDR_BITS-1:0]      wr_ptr_q, rd_ptr_q;
	logic [tcr_pkg::QCNT_BITS-1:0]       count_q;
	logic                                do_push, do_pop;

	assign push_stall = (count_q == tcr_pkg::QCNT_BITS'(tcr_pkg::QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = slot_q[rd_ptr_q];
	assign do_push    = push_valid && !push_stall;
	assign do_pop     = pop_valid && !pop_stall;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: design/tcr_back.sv
// Back end: four-stage edge-function pipeline that decides pixel coverage.
module tcr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_stall,
	input  tcr_pkg::entry_t pop_entry,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            valid_res,
	output tcr_pkg::coord_t pixel_x,
	output tcr_pkg::coord_t pixel_y,
	output logic            covered,
	output logic            last
);

	// Stage 1: offsets from vertex A.
	logic            v_s1;
	tcr_pkg::meta_t  meta_s1;
	tcr_pkg::diff_t  e1x_s1, e1y_s1, e2x_s1, e2y_s1, dx_s1, dy_s1;
	// Stage 2: the six partial products.
	logic            v_s2;
	tcr_pkg::meta_t  meta_s2;
	tcr_pkg::prod_t  p_e2x_dy_s2, p_dx_e2y_s2, p_dx_e1y_s2;
	tcr_pkg::prod_t  p_e1x_dy_s2, p_e1x_e2y_s2, p_e2x_e1y_s2;
	// Stage 3: edge weights and doubled area.
	logic            v_s3;
	tcr_pkg::meta_t  meta_s3;
	tcr_pkg::prod_t  wb_s3, wc_s3, area_s3;
	// Stage 4: output register.
	logic            v_s4;
	tcr_pkg::meta_t  meta_s4;
	logic            cov_s4;

	logic            adv1, adv2, adv3, adv4;
	tcr_pkg::sum_t   wa, wb_ext, wc_ext, area_ext;
	logic            area_pos, all_pos, all_neg, cov_next;

	assign adv4      = !v_s4 || !out_stall;
	assign adv3      = !v_s3 || adv4;
	assign adv2      = !v_s2 || adv3;
	assign adv1      = !v_s1 || adv2;
	assign pop_stall = !adv1;

	assign wb_ext   = tcr_pkg::SUM_BITS'(wb_s3);
	assign wc_ext   = tcr_pkg::SUM_BITS'(wc_s3);
	assign area_ext = tcr_pkg::SUM_BITS'(area_s3);
	assign wa       = area_ext - wb_ext - wc_ext;
	assign area_pos = (area_s3 > 0);
	assign all_pos  = (wa > 0) && (wb_s3 > 0) && (wc_s3 > 0);
	assign all_neg  = (wa < 0) && (wb_s3 < 0) && (wc_s3 < 0);
	assign cov_next = meta_s3.pix && (area_s3 != '0) && (area_pos ? all_pos : all_neg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= pop_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			meta_s1 <= pop_entry.meta;
			e1x_s1  <= pop_entry.geom.e1x;
			e1y_s1  <= pop_entry.geom.e1y;
			e2x_s1  <= pop_entry.geom.e2x;
			e2y_s1  <= pop_entry.geom.e2y;
			dx_s1   <= tcr_pkg::coord_diff(pop_entry.geom.ax, pop_entry.meta.x);
			dy_s1   <= tcr_pkg::coord_diff(pop_entry.geom.ay, pop_entry.meta.y);
		end
		if (adv2) begin
			meta_s2      <= meta_s1;
			p_e2x_dy_s2  <= e2x_s1 * dy_s1;
			p_dx_e2y_s2  <= dx_s1 * e2y_s1;
			p_dx_e1y_s2  <= dx_s1 * e1y_s1;
			p_e1x_dy_s2  <= e1x_s1 * dy_s1;
			p_e1x_e2y_s2 <= e1x_s1 * e2y_s1;
			p_e2x_e1y_s2 <= e2x_s1 * e1y_s1;
		end
		if (adv3) begin
			meta_s3 <= meta_s2;
			wb_s3   <= p_e2x_dy_s2 - p_dx_e2y_s2;
			wc_s3   <= p_dx_e1y_s2 - p_e1x_dy_s2;
			area_s3 <= p_e1x_e2y_s2 - p_e2x_e1y_s2;
		end
		if (adv4) begin
			meta_s4 <= meta_s3;
			cov_s4  <= cov_next;
		end
	end

	assign out_valid = v_s4;
	assign valid_res = meta_s4.pix;
	assign pixel_x   = meta_s4.x;
	assign pixel_y   = meta_s4.y;
	assign covered   = cov_s4;
	assign last      = meta_s4.last;

endmodule

// File: design/triangle_coverage_raster.sv
// Top level of the triangle coverage rasterizer: front end, queue and coverage pipeline.
// A result passes through a queue slot and then the back-end pipeline registers before it reaches the output.
// Throughput: one transaction per cycle while neither the queue nor the output stalls.
// The four-entry queue lets the front end keep accepting while the output is stalled, until the queue is full.
// Reset is asynchronous and active low; it clears the stored triangle, bounds, cursor,
// the queue and all pipeline valid bits, leaving no triangle loaded.
module triangle_coverage_raster (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            kind,
	input  tcr_pkg::coord_t vertex_ax,
	input  tcr_pkg::coord_t vertex_ay,
	input  tcr_pkg::coord_t vertex_bx,
	input  tcr_pkg::coord_t vertex_by,
	input  tcr_pkg::coord_t vertex_cx,
	input  tcr_pkg::coord_t vertex_cy,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            valid_res,
	output tcr_pkg::coord_t pixel_x,
	output tcr_pkg::coord_t pixel_y,
	output logic            covered,
	output logic            last
);

	// Every accepted transaction, load or step, turns into exactly one queue entry.
	// Step transactions on an active triangle carry the pixel position and the
	// triangle's edge vectors, so a later load cannot disturb pixels still in flight.
	logic            push_valid, push_stall;
	tcr_pkg::entry_t push_entry;
	logic            pop_valid, pop_stall;
	tcr_pkg::entry_t pop_entry;

	// The front end owns the vertex store, bounding box and scan cursor.
	// It walks the box with x as the outer loop and y as the inner loop.
	tcr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.vertex_ax  (vertex_ax),
		.vertex_ay  (vertex_ay),
		.vertex_bx  (vertex_bx),
		.vertex_by  (vertex_by),
		.vertex_cx  (vertex_cx),
		.vertex_cy  (vertex_cy),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_entry (push_entry)
	);

	// The queue lets the front and back halves stall independently.
	tcr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_stall  (pop_stall),
		.pop_entry  (pop_entry)
	);

	// The back end evaluates the exact integer edge functions. A pixel counts as
	// covered only if the area is nonzero and all three weights share its sign
	// strictly, so pixels on an edge or vertex are never covered.
	tcr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_stall  (pop_stall),
		.pop_entry  (pop_entry),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.valid_res  (valid_res),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.covered    (covered),
		.last       (last)
	);

endmodule

// File: design/tcr_checker.sv
// Port-level checker for the triangle coverage rasterizer and its bind statement.
module tcr_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            out_valid,
	input logic            out_stall,
	input logic            valid_res,
	input tcr_pkg::coord_t pixel_x,
	input tcr_pkg::coord_t pixel_y,
	input logic            covered,
	input logic            last
);

	// A stalled output transaction must stay offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output transaction dropped while stalled");

	// Loads and idle steps give an all-zero result.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> pixel_x == '0 && pixel_y == '0 && !covered && !last)
		else $error("non-pixel result carries nonzero fields");

	// Coverage and end-of-box flags only come with a pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (covered || last) |-> valid_res)
		else $error("coverage or last flag without a pixel");

	// If a pixel that is not the last of its box is directly followed by another pixel, that
	// pixel is either the next one of the same column or a pixel of the next column.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && valid_res && !last ##1 out_valid && valid_res
		|-> (pixel_x == $past(pixel_x) && pixel_y == $past(pixel_y) + 1'b1)
			|| pixel_x == $past(pixel_x) + 1'b1)
		else $error("pixel ordering broken");

endmodule

bind triangle_coverage_raster tcr_checker u_tcr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.valid_res (valid_res),
	.pixel_x   (pixel_x),
	.pixel_y   (pixel_y),
	.covered   (covered),
	.last      (last)
);

// File: tb/tb_triangle_coverage_raster.sv
// Self-checking testbench for the triangle coverage rasterizer: directed scans, then random triangles.
`timescale 1ns / 100ps

module tb_triangle_coverage_raster;

	// One output transaction of the rasterizer, as the scoreboard holds it.
	typedef struct packed {
		logic            valid_res;
		tcr_pkg::coord_t x;
		tcr_pkg::coord_t y;
		logic            covered;
		logic            last;
	} pixel_result_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_stall;
	logic            kind = tcr_pkg::KIND_STEP;
	tcr_pkg::coord_t vertex_ax = '0;
	tcr_pkg::coord_t vertex_ay = '0;
	tcr_pkg::coord_t vertex_bx = '0;
	tcr_pkg::coord_t vertex_by = '0;
	tcr_pkg::coord_t vertex_cx = '0;
	tcr_pkg::coord_t vertex_cy = '0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	logic            valid_res;
	tcr_pkg::coord_t pixel_x;
	tcr_pkg::coord_t pixel_y;
	logic            covered;
	logic            last;

	// Mirror of the rasterizer state, advanced once per accepted input transaction.
	tcr_pkg::coord_t tri_x [3];
	tcr_pkg::coord_t tri_y [3];
	tcr_pkg::coord_t box_min_x, box_min_y, box_max_x, box_max_y;
	tcr_pkg::coord_t scan_x, scan_y;
	logic            scan_busy;

	// Pixels predicted but not yet seen on the output, oldest first.
	pixel_result_t expected_pixels [$];

	int txn_count = 0;
	int error_count = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;

	triangle_coverage_raster DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.vertex_ax (vertex_ax),
		.vertex_ay (vertex_ay),
		.vertex_bx (vertex_bx),
		.vertex_by (vertex_by),
		.vertex_cx (vertex_cx),
		.vertex_cy (vertex_cy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.valid_res (valid_res),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.covered   (covered),
		.last      (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Advances the mirrored state by one input transaction and returns the result that
	// the rasterizer must produce for it. Every transaction yields exactly one result;
	// loads and steps with no triangle loaded give an all-zero result.
	function automatic pixel_result_t predict_pixel(input logic k,
		input tcr_pkg::coord_t ax, ay, bx, by, cx, cy);
		pixel_result_t r;
		longint e1x, e1y, e2x, e2y, dx, dy, wa, wb, wc, area;
		logic end_col, end_all;
		int i;
		r = '0;
		if (k == tcr_pkg::KIND_LOAD) begin
			tri_x = '{ax, bx, cx};
			tri_y = '{ay, by, cy};
			box_min_x = ax;
			box_max_x = ax;
			box_min_y = ay;
			box_max_y = ay;
			for (i = 1; i < 3; i++) begin
				if (tri_x[i] < box_min_x) box_min_x = tri_x[i];
				if (tri_x[i] > box_max_x) box_max_x = tri_x[i];
				if (tri_y[i] < box_min_y) box_min_y = tri_y[i];
				if (tri_y[i] > box_max_y) box_max_y = tri_y[i];
			end
			scan_x = box_min_x;
			scan_y = box_min_y;
			scan_busy = 1'b1;
			return r;
		end
		if (!scan_busy)
			return r;

		// Exact edge functions relative to vertex A. A pixel counts only when all three
		// weights share the strict sign of the area, so edges and vertices are excluded
		// and a zero-area triangle covers nothing.
		e1x = longint'(tri_x[1]) - longint'(tri_x[0]);
		e1y = longint'(tri_y[1]) - longint'(tri_y[0]);
		e2x = longint'(tri_x[2]) - longint'(tri_x[0]);
		e2y = longint'(tri_y[2]) - longint'(tri_y[0]);
		dx = longint'(tri_x[0]) - longint'(scan_x);
		dy = longint'(tri_y[0]) - longint'(scan_y);
		wb = e2x * dy - dx * e2y;
		wc = dx * e1y - e1x * dy;
		area = e1x * e2y - e2x * e1y;
		wa = area - wb - wc;

		end_col = (scan_y >= box_max_y);
		end_all = end_col && (scan_x >= box_max_x);
		r.valid_res = 1'b1;
		r.x = scan_x;
		r.y = scan_y;
		if (area > 0)
			r.covered = (wa > 0) && (wb > 0) && (wc > 0);
		else if (area < 0)
			r.covered = (wa < 0) && (wb < 0) && (wc < 0);
		r.last = end_all;

		// Column-major walk: y runs inside, x steps when a column is done.
		if (end_all) begin
			scan_busy = 1'b0;
		end else if (end_col) begin
			scan_y = box_min_y;
			scan_x = scan_x + 1'b1;
		end else begin
			scan_y = scan_y + 1'b1;
		end
		return r;
	endfunction

	// Offers one input transaction, optionally after a short idle gap, and holds the
	// payload until the rasterizer takes it. The expectation is queued at the edge of
	// acceptance. The task returns at that edge with in_valid still high, so a following
	// call can keep it high without a glitch.
	task automatic send_txn(input logic k, input tcr_pkg::coord_t ax, ay, bx, by, cx, cy);
		if ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		vertex_ax <= ax;
		vertex_ay <= ay;
		vertex_bx <= bx;
		vertex_by <= by;
		vertex_cx <= cx;
		vertex_cy <= cy;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_pixels.insert(expected_pixels.size(),
			predict_pixel(k, ax, ay, bx, by, cx, cy));
		txn_count++;
	endtask

	task automatic load_triangle(input tcr_pkg::coord_t ax, ay, bx, by, cx, cy);
		send_txn(tcr_pkg::KIND_LOAD, ax, ay, bx, by, cx, cy);
	endtask

	// A step carries random vertex bits; the rasterizer must ignore them.
	task automatic step_pixels(input int count);
		repeat (count)
			send_txn(tcr_pkg::KIND_STEP,
				tcr_pkg::coord_t'($urandom_range(4095)),
				tcr_pkg::coord_t'($urandom_range(4095)),
				tcr_pkg::coord_t'($urandom_range(4095)),
				tcr_pkg::coord_t'($urandom_range(4095)),
				tcr_pkg::coord_t'($urandom_range(4095)),
				tcr_pkg::coord_t'($urandom_range(4095)));
	endtask

	// Holds the sender off until every predicted pixel has come out. It always waits
	// at least one edge, so in_valid is never lowered and raised in the same step.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_pixels.size() != 0) @(posedge clk);
	endtask

	task automatic note_failure(input string what);
		if (error_count < 10)
			$display("%t: %s", $realtime, what);
		error_count++;
	endtask

	// A step before any load must give an all-zero result and change nothing.
	task automatic test_step_while_idle();
		step_pixels(1);
	endtask

	// Full scan of a small counter-clockwise triangle: vertices and edges are not
	// covered, the single interior pixel (1,1) is, and the last flag ends the box.
	task automatic test_full_scan();
		load_triangle(12'd0, 12'd0, 12'd2, 12'd1, 12'd1, 12'd2);
		step_pixels(9);
	endtask

	// A load in the middle of a scan drops the old box. The new triangle collapses to
	// one pixel at the top corner of the coordinate range, so its only pixel is also the
	// last one, and the step after it finds the rasterizer idle again.
	task automatic test_reload_mid_scan();
		load_triangle(12'd10, 12'd20, 12'd14, 12'd20, 12'd10, 12'd26);
		step_pixels(2);
		load_triangle(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
		step_pixels(2);
	endtask

	// Clockwise triangle against the top of the range, so the area is negative and the
	// cursor reaches the largest coordinate on both axes.
	task automatic test_clockwise_at_range_top();
		load_triangle(12'd4095, 12'd4095, 12'd4094, 12'd4093, 12'd4093, 12'd4094);
		step_pixels(9);
	endtask

	// Mostly well-formed scans of small triangles placed anywhere in the coordinate
	// range, some complete, some cut short by the next load, some followed by idle
	// steps. A few loads take arbitrary coordinates and are abandoned after a handful of
	// steps, and some triangles are made degenerate on purpose.
	task automatic test_random_scans(input int n_txn);
		int start;
		int pick;
		int w, h;
		int steps;
		int i;
		tcr_pkg::coord_t org_x, org_y;
		tcr_pkg::coord_t v [6];
		start = txn_count;
		while (txn_count - start < n_txn) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				for (i = 0; i < 6; i++)
					v[i] = tcr_pkg::coord_t'($urandom_range(4095));
				load_triangle(v[0], v[1], v[2], v[3], v[4], v[5]);
				steps = $urandom_range(4);
			end else begin
				if (pick < 16) begin
					w = $urandom_range(6, 14);
					h = $urandom_range(6, 14);
				end else begin
					w = $urandom_range(5);
					h = $urandom_range(5);
				end
				// A quarter of the boxes touch the top of the range on each axis.
				org_x = ($urandom_range(3) == 0) ? tcr_pkg::coord_t'(4095 - w)
					: tcr_pkg::coord_t'($urandom_range(4095 - w));
				org_y = ($urandom_range(3) == 0) ? tcr_pkg::coord_t'(4095 - h)
					: tcr_pkg::coord_t'($urandom_range(4095 - h));
				for (i = 0; i < 3; i++) begin
					v[2*i]   = org_x + tcr_pkg::coord_t'($urandom_range(w));
					v[2*i+1] = org_y + tcr_pkg::coord_t'($urandom_range(h));
				end
				// Repeating a vertex gives a zero-area triangle with a real box.
				if (pick < 24) begin
					v[4] = v[0];
					v[5] = v[1];
				end
				load_triangle(v[0], v[1], v[2], v[3], v[4], v[5]);
				steps = (int'(box_max_x) - int'(box_min_x) + 1)
					* (int'(box_max_y) - int'(box_min_y) + 1);
				if ($urandom_range(4) == 0)
					steps = $urandom_range(steps - 1);
				else if ($urandom_range(3) == 0)
					steps += $urandom_range(1, 2);
			end
			step_pixels(steps);
		end
	endtask

	// The receiver stalls at random at the rate of the current phase.
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < sink_stall_pct);

	// Each output transaction is checked against the oldest prediction.
	always @(posedge clk) begin
		pixel_result_t want;
		pixel_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{valid_res, pixel_x, pixel_y, covered, last};
			if (expected_pixels.size() == 0) begin
				note_failure($sformatf("unexpected result v=%0d x=%0d y=%0d cov=%0d last=%0d",
					got.valid_res, got.x, got.y, got.covered, got.last));
			end else begin
				want = expected_pixels.pop_front();
				if (got.valid_res !== want.valid_res || got.x !== want.x || got.y !== want.y
					|| got.covered !== want.covered || got.last !== want.last)
					note_failure($sformatf({"mismatch: expected v=%0d x=%0d y=%0d cov=%0d ",
						"last=%0d, got v=%0d x=%0d y=%0d cov=%0d last=%0d"},
						want.valid_res, want.x, want.y, want.covered, want.last,
						got.valid_res, got.x, got.y, got.covered, got.last));
			end
		end
	end

	initial begin
		tri_x = '{3{12'd0}};
		tri_y = '{3{12'd0}};
		box_min_x = '0;
		box_min_y = '0;
		box_max_x = '0;
		box_max_y = '0;
		scan_x = '0;
		scan_y = '0;
		scan_busy = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// First phase: the sender idles now and then, the receiver stalls half the time.
		src_idle_pct = 26;
		sink_stall_pct = 50;
		test_step_while_idle();
		test_full_scan();
		test_reload_mid_scan();
		test_clockwise_at_range_top();
		test_random_scans(150);
		// Let the pipeline run empty once in the middle of traffic.
		wait_for_results();
		test_random_scans(150);

		// Second phase: the roles swap.
		src_idle_pct = 50;
		sink_stall_pct = 26;
		test_random_scans(300);

		// Last phase: back-to-back transactions with no stalls at all.
		wait_for_results();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		test_random_scans(300);

		// Drain, then let any stray result still in the pipeline come out before the verdict.
		wait_for_results();
		repeat (16) @(posedge clk);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
